/* hw/rtl/rgb_to_hsv_converter_defines.svh */
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Checks that are meaningless while the block sits in reset.
`define RTH_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checks that must also hold while reset is asserted.
`define RTH_ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/rth_pkg.sv */
package rth_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CHAN_W = 8;
	localparam int HUE_W = 16;
	localparam int SAT_W = 17;

	// One quotient bit per divider stage; the top bit is the integer part.
	localparam int QUO_W = FRAC_BITS + 1;
	localparam int DIV_STAGES = QUO_W;
	localparam int DIV_LAST = DIV_STAGES - 1;

	// Hue divisor is six times the chroma, below eight times the channel range.
	localparam int HDIV_W = CHAN_W + 3;
	localparam int HREM_W = HDIV_W + 1;
	localparam int SREM_W = CHAN_W + 1;
	localparam int NUM_W = HDIV_W + 2;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [HUE_W-1:0] hue_t;
	typedef logic [SAT_W-1:0] sat_t;
	typedef logic [QUO_W-1:0] quo_t;

	// Sector offset in sixths of a turn.
	typedef enum logic [1:0] {
		SEC_0,
		SEC_M6,
		SEC_M2,
		SEC_P4
	} sector_t;

	typedef struct packed {
		chan_t hi;
		chan_t mid;
		chan_t lo;
		sector_t sec;
	} sort_t;

	typedef struct packed {
		logic [HREM_W-1:0] hrem;
		logic [HDIV_W-1:0] hdiv;
		quo_t hq;
		logic [SREM_W-1:0] srem;
		chan_t sdiv;
		quo_t sq;
		chan_t bright;
	} div_t;

	// One restoring step for both divisions: compare, subtract, shift.
	function automatic div_t div_step(div_t d);
		div_t n;
		logic hbit;
		logic sbit;
		logic [HDIV_W-1:0] hdiff;
		chan_t sdiff;
		n = d;
		hbit = d.hrem >= {1'b0, d.hdiv};
		hdiff = hbit ? HDIV_W'(d.hrem - {1'b0, d.hdiv}) : HDIV_W'(d.hrem);
		sbit = d.srem >= {1'b0, d.sdiv};
		sdiff = sbit ? CHAN_W'(d.srem - {1'b0, d.sdiv}) : CHAN_W'(d.srem);
		n.hrem = {hdiff, 1'b0};
		n.hq = {d.hq[QUO_W-2:0], hbit};
		n.srem = {sdiff, 1'b0};
		n.sq = {d.sq[QUO_W-2:0], sbit};
		return n;
	endfunction

endpackage

/* hw/rtl/rth_if.sv */
interface rth_rgb_if;
	import rth_pkg::*;

	logic valid;
	logic ready;
	chan_t red;
	chan_t green;
	chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if;
	import rth_pkg::*;

	logic valid;
	logic ready;
	hue_t hue;
	sat_t saturation;
	chan_t brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

/* hw/rtl/rgb_to_hsv_converter.sv */
// RGB to HSV converter. Takes one pixel per clock while the pipeline is not held
// up by the output and returns hue, saturation and value. One stage sorts the
// channels, one forms chroma and the hue numerator, and 17 stages each produce one
// quotient bit of both the hue and the saturation division. Every stage has its own
// valid bit and moves on whenever the stage after it is empty or moving, so bubbles
// close up and the input keeps being accepted while a result waits at the output
// register, until the pipeline is full. Hue is a 16-bit fraction of a turn,
// saturation a 17-bit fraction where 65536 means one, brightness the largest
// channel; grey pixels give zero hue and saturation. There is no configuration and
// no state beyond the pipeline itself.
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter (
	input logic clk,
	input logic arst_n,
	rth_rgb_if.sink rgb,
	rth_hsv_if.source hsv
);
	import rth_pkg::*;

	logic valid_s1;
	sort_t sort_s1;
	logic valid_s2;
	div_t seed_s2;

	// Element k of the two arrays below is pipeline stage 3 + k.
	logic dv_valid_s3 [DIV_STAGES];
	div_t dv_s3 [DIV_STAGES];

	logic dv_vin [DIV_STAGES];
	div_t dv_in [DIV_STAGES];
	logic div_go [DIV_STAGES+1];
	logic s1_go;
	logic s2_go;

	sort_t sort_d;
	div_t seed_d;

	// Stage 1: move the largest channel to the top by two swaps and track the sector.
	always_comb begin
		logic sw1;
		logic sw2;
		chan_t g0;
		chan_t b0;
		sw1 = rgb.green < rgb.blue;
		g0 = sw1 ? rgb.blue : rgb.green;
		b0 = sw1 ? rgb.green : rgb.blue;
		sw2 = rgb.red < g0;
		sort_d.hi = sw2 ? g0 : rgb.red;
		sort_d.mid = sw2 ? rgb.red : g0;
		sort_d.lo = b0;
		if (sw2) begin
			sort_d.sec = sw1 ? SEC_P4 : SEC_M2;
		end else begin
			sort_d.sec = sw1 ? SEC_M6 : SEC_0;
		end
	end

	// Stage 2: chroma, absolute hue numerator and the two divisors.
	always_comb begin
		chan_t mn;
		chan_t chroma;
		logic signed [NUM_W-1:0] cs;
		logic signed [NUM_W-1:0] diff;
		logic signed [NUM_W-1:0] prod;
		logic signed [NUM_W-1:0] num;
		logic signed [NUM_W-1:0] mag;
		logic [HDIV_W-1:0] six_c;
		mn = (sort_s1.mid < sort_s1.lo) ? sort_s1.mid : sort_s1.lo;
		chroma = sort_s1.hi - mn;
		cs = $signed(NUM_W'(chroma));
		diff = $signed(NUM_W'(sort_s1.mid)) - $signed(NUM_W'(sort_s1.lo));
		case (sort_s1.sec)
			SEC_0: begin
				prod = '0;
			end
			SEC_M6: begin
				prod = -((cs <<< 2) + (cs <<< 1));
			end
			SEC_M2: begin
				prod = -(cs <<< 1);
			end
			SEC_P4: begin
				prod = cs <<< 2;
			end
			default: begin
				prod = '0;
			end
		endcase
		num = prod + diff;
		mag = (num < 0) ? -num : num;
		six_c = HDIV_W'({chroma, 2'b00}) + HDIV_W'({chroma, 1'b0});
		seed_d.hrem = HREM_W'(mag[HDIV_W-1:0]);
		// A grey pixel has a zero numerator; a full divisor keeps its quotient zero.
		seed_d.hdiv = (chroma == '0) ? '1 : six_c;
		seed_d.hq = '0;
		seed_d.srem = SREM_W'(chroma);
		seed_d.sdiv = (sort_s1.hi == '0) ? CHAN_W'(1) : sort_s1.hi;
		seed_d.sq = '0;
		seed_d.bright = sort_s1.hi;
	end

	assign div_go[DIV_STAGES] = hsv.ready;
	assign s2_go = !valid_s2 || div_go[0];
	assign s1_go = !valid_s1 || s2_go;
	assign rgb.ready = s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_go) begin
				valid_s1 <= rgb.valid;
			end
			if (s2_go) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && rgb.valid) begin
			sort_s1 <= sort_d;
		end
		if (s2_go && valid_s1) begin
			seed_s2 <= seed_d;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		if (k == 0) begin : g_first
			assign dv_vin[k] = valid_s2;
			assign dv_in[k] = seed_s2;
		end else begin : g_next
			assign dv_vin[k] = dv_valid_s3[k-1];
			assign dv_in[k] = dv_s3[k-1];
		end

		assign div_go[k] = !dv_valid_s3[k] || div_go[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s3[k] <= 1'b0;
			end else if (div_go[k]) begin
				dv_valid_s3[k] <= dv_vin[k];
			end
		end

		always_ff @(posedge clk) begin
			if (div_go[k] && dv_vin[k]) begin
				dv_s3[k] <= div_step(dv_in[k]);
			end
		end
	end

	assign hsv.valid = dv_valid_s3[DIV_LAST];
	assign hsv.hue = hue_t'(dv_s3[DIV_LAST].hq);
	assign hsv.saturation = sat_t'(dv_s3[DIV_LAST].sq);
	assign hsv.brightness = dv_s3[DIV_LAST].bright;

	`RTH_ASSERT(a_in_lands, rgb.valid && rgb.ready |=> valid_s1, "accepted pixel not in stage 1")
	`RTH_ASSERT(a_hue_below_turn, dv_valid_s3[DIV_LAST] |-> !dv_s3[DIV_LAST].hq[QUO_W-1], "hue quotient reached a full turn")
	`RTH_ASSERT(a_sat_bound, dv_valid_s3[DIV_LAST] && dv_s3[DIV_LAST].sq[QUO_W-1] |-> dv_s3[DIV_LAST].sq[QUO_W-2:0] == '0, "saturation above one")
	`RTH_ASSERT(a_black_zero, hsv.valid && hsv.brightness == '0 |-> hsv.hue == '0 && hsv.saturation == '0, "black pixel gave nonzero hue or saturation")
	`RTH_ASSERT_RST(a_reset_empty, !arst_n |-> !hsv.valid && !valid_s1 && !valid_s2, "pipeline not empty in reset")

endmodule

/* tb/tb_rgb_to_hsv_converter.sv */
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter;
	import rth_pkg::*;

	localparam int PIPE_LATENCY = 19;
	localparam int STALL_LEN = 150;
	localparam int MAX_REPORTS = 40;
	localparam int ITEMS_PER_PHASE = 240;

	typedef struct {
		hue_t hue;
		sat_t saturation;
		chan_t brightness;
	} hsv_triplet_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	rth_rgb_if rgb_bus ();
	rth_hsv_if hsv_bus ();

	rgb_to_hsv_converter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rgb(rgb_bus),
		.hsv(hsv_bus)
	);

	hsv_triplet_t pending_hsv[$];
	int mismatch_count = 0;
	int pixels_sent = 0;
	int results_checked = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cycles_left = 0;

	always #5 clk = ~clk;

	// Exact integer HSV: sort by two swaps, track the sector offset in sixths of a turn.
	function automatic hsv_triplet_t convert_pixel(chan_t r_in, chan_t g_in, chan_t b_in);
		hsv_triplet_t res;
		int hi;
		int mid;
		int lo;
		int tmp;
		int offset;
		int low_chan;
		int chroma;
		int num;
		longint unsigned hue_q;
		longint unsigned sat_q;
		hi = r_in;
		mid = g_in;
		lo = b_in;
		offset = 0;
		hue_q = 0;
		sat_q = 0;
		if (mid < lo) begin
			tmp = mid;
			mid = lo;
			lo = tmp;
			offset = -6;
		end
		if (hi < mid) begin
			tmp = hi;
			hi = mid;
			mid = tmp;
			offset = -2 - offset;
		end
		low_chan = (mid < lo) ? mid : lo;
		chroma = hi - low_chan;
		if (chroma != 0) begin
			num = offset * chroma + (mid - lo);
			if (num < 0)
				num = -num;
			hue_q = (longint'(num) << FRAC_BITS) / longint'(6 * chroma);
			sat_q = (longint'(chroma) << FRAC_BITS) / longint'(hi);
		end
		res.hue = hue_t'(hue_q);
		res.saturation = sat_t'(sat_q);
		res.brightness = chan_t'(hi);
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Offers one pixel and returns at the edge where the transaction is accepted.
	task automatic send_pixel(chan_t r_val, chan_t g_val, chan_t b_val);
		while ($urandom_range(99) < send_idle_pct) begin
			rgb_bus.valid <= 1'b0;
			@(posedge clk);
		end
		rgb_bus.valid <= 1'b1;
		rgb_bus.red <= r_val;
		rgb_bus.green <= g_val;
		rgb_bus.blue <= b_val;
		@(posedge clk);
		while (!rgb_bus.ready)
			@(posedge clk);
		pending_hsv.push_back(convert_pixel(r_val, g_val, b_val));
		pixels_sent++;
	endtask

	task automatic send_random_pixel();
		chan_t chan[3];
		int pick;
		for (int i = 0; i < 3; i++)
			chan[i] = chan_t'($urandom_range(255));
		case ($urandom_range(9))
			0: begin
				chan[1] = chan[0];
				chan[2] = chan[0];
			end
			1: begin
				pick = $urandom_range(2);
				chan[pick] = chan[(pick + 1) % 3];
			end
			2: begin
				for (int i = 0; i < 3; i++)
					if ($urandom_range(1))
						chan[i] = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			default: ;
		endcase
		send_pixel(chan[0], chan[1], chan[2]);
	endtask

	task automatic wait_for_results();
		rgb_bus.valid <= 1'b0;
		while (pending_hsv.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_colors();
		send_idle_pct = 27;
		recv_idle_pct = 86;
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		// Ties in the sort must keep their order.
		send_pixel(8'd200, 8'd200, 8'd100);
		send_pixel(8'd100, 8'd200, 8'd200);
		send_pixel(8'd200, 8'd100, 8'd200);
		send_pixel(8'd100, 8'd100, 8'd200);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		// Hue just below one full turn and just above zero.
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd1, 8'd0);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd1, 8'd255, 8'd254);
		send_pixel(8'd85, 8'd170, 8'd255);
		wait_for_results();
	endtask

	task automatic test_random_pixels(int snd_pct, int rcv_pct);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		repeat (ITEMS_PER_PHASE)
			send_random_pixel();
	endtask

	// The output is held off long enough that the pipeline fills and the input stalls.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_cycles_left = STALL_LEN;
		repeat (60)
			send_random_pixel();
		wait_for_results();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_bus.ready <= 1'b0;
		end else if (stall_cycles_left > 0) begin
			hsv_bus.ready <= 1'b0;
			stall_cycles_left--;
		end else begin
			hsv_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		hsv_triplet_t want;
		if (arst_n && hsv_bus.valid && hsv_bus.ready) begin
			if (pending_hsv.size() == 0) begin
				report_mismatch("result with no pixel outstanding", hsv_bus.hue, -1);
			end else begin
				want = pending_hsv.pop_front();
				results_checked++;
				if (hsv_bus.hue !== want.hue)
					report_mismatch("hue", hsv_bus.hue, want.hue);
				if (hsv_bus.saturation !== want.saturation)
					report_mismatch("saturation", hsv_bus.saturation, want.saturation);
				if (hsv_bus.brightness !== want.brightness)
					report_mismatch("brightness", hsv_bus.brightness, want.brightness);
			end
		end
	end

	initial begin
		rgb_bus.valid = 1'b0;
		rgb_bus.red = '0;
		rgb_bus.green = '0;
		rgb_bus.blue = '0;
		// Reset falls after time zero so that every reset process sees the edge.
		#1;
		arst_n = 1'b0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_colors();
		test_random_pixels(27, 86);
		test_random_pixels(86, 27);
		test_random_pixels(0, 0);
		// The sender waits here until every outstanding pixel has come back.
		wait_for_results();
		test_output_backpressure();
		repeat (PIPE_LATENCY + 5)
			@(posedge clk);
		$display("Converted %0d pixels, %0d results checked, across grey, tie and extreme",
			pixels_sent, results_checked);
		$display("colors under three pacing mixes and a %0d-cycle output stall.", STALL_LEN);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d results outstanding.", pending_hsv.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
